// ===== sv/pas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon area statistics package
// Shared widths, codes, word types and controller command and status types.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int COORD_BITS   = 16;
    localparam int PROD_W       = 2 * COORD_BITS;
    localparam int ACC_W        = 44;
    localparam int AREA_W       = 42;
    localparam int SUM_W        = 60;
    localparam int CNT_W        = 17;
    localparam int VCNT_W       = 11;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_POLYGONS = 65536;
    localparam int NUM_W        = 64;
    localparam int REM_W        = CNT_W + 1;
    localparam int DIV_STEPS    = NUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int MODE_W       = 2;
    localparam int TARGET_W     = 11;
    localparam int STATUS_W     = 2;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int BAD_TARGET_MAX = 2;

    // Selection modes.
    localparam logic [MODE_W-1:0] MODE_EVEN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ODD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALL   = 2'd3;

    // Register indexes.
    localparam logic REG_SELECT_MODE = 1'b0;
    localparam logic REG_TARGET      = 1'b1;

    localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_ALL;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_VALID      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TARGET = 2'd2;

    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last_vertex;
    } t_in_word;

    typedef struct packed {
        logic [SUM_W-1:0]    twice_area_sum;
        logic [CNT_W-1:0]    selected_count;
        logic [SUM_W-1:0]    mean_area_tenths;
        logic [AREA_W-1:0]   max_twice_area;
        logic [AREA_W-1:0]   min_twice_area;
        logic [VCNT_W-1:0]   max_vertices;
        logic [VCNT_W-1:0]   min_vertices;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VTX_ACC,
        ST_CLS_MUL,
        ST_CLS_ACC,
        ST_CLS_UPD,
        ST_DIV_PREP,
        ST_DIV_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic vtx_load;
        logic vtx_acc;
        logic cls_mul;
        logic cls_acc;
        logic cls_upd;
        logic div_prep;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic cnt_zero;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/pas_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon area statistics configuration registers
// APB-style register file holding the selection mode and the target count.
// ----------------------------------------------------------------------------
module pas_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pas_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pas_pkg::PDATA_W-1:0]   pwdata,
    output logic      [pas_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [pas_pkg::MODE_W-1:0]    o_mode,
    output logic      [pas_pkg::TARGET_W-1:0]  o_target
);
    import pas_pkg::*;

    logic                wr_en;
    logic                reg_idx;
    logic [MODE_W-1:0]   r_mode;
    logic [TARGET_W-1:0] r_target;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_target <= TARGET_RESET;
        end else if (wr_en) begin
            if (reg_idx == REG_SELECT_MODE) begin
                r_mode <= pwdata[MODE_W-1:0];
            end else begin
                r_target <= pwdata[TARGET_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_SELECT_MODE) begin
            prdata = PDATA_W'(r_mode);
        end else begin
            prdata = PDATA_W'(r_target);
        end
    end

    assign o_mode   = r_mode;
    assign o_target = r_target;

endmodule
`default_nettype wire

// ===== sv/pas_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon area statistics datapath
// Cross-product multipliers, shoelace accumulator, set statistics, serial
// divider for the mean and the output word register.
// ----------------------------------------------------------------------------
module pas_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pas_pkg::t_cmd                i_cmd,
    output pas_pkg::t_sts                     o_sts,
    input  wire pas_pkg::t_in_word            i_word,
    input  wire logic [pas_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [pas_pkg::TARGET_W-1:0] i_target,
    output pas_pkg::t_out_word                o_word,
    output logic                              o_valid,
    input  wire logic                         i_stall
);
    import pas_pkg::*;

    // Vertex state.
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [PROD_W-1:0]     r_pa, r_pb;
    logic signed [ACC_W-1:0]      r_acc;
    logic [VCNT_W-1:0]            r_vcount;
    logic                         r_add;
    logic                         r_last;
    logic [AREA_W-1:0]            r_mag;
    logic [VCNT_W-1:0]            r_n;

    // Set statistics.
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_poly_cnt;
    logic [CNT_W-1:0]  r_pick;
    logic [AREA_W-1:0] r_max_area, r_min_area;
    logic [VCNT_W-1:0] r_max_n, r_min_n;

    // Divider.
    logic [NUM_W-1:0]     r_num;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Output register.
    t_out_word r_out;
    logic      r_out_valid;

    logic signed [COORD_BITS-1:0] op_by, op_bx;
    logic signed [PROD_W:0]       diff;
    logic signed [ACC_W-1:0]      diff_ext, acc_fin;
    logic [ACC_W-1:0]             mag_full;
    logic                         picked;
    logic [SUM_W:0]               sum_add;
    logic [REM_W:0]               rem_sh, den;
    logic                         rem_ge;
    logic                         bad_target;
    logic                         empty;
    logic [SUM_W-1:0]             mean_sat;

    // The closing cross product pairs the last vertex with the first.
    assign op_by    = i_cmd.cls_mul ? r_first_y : i_word.y;
    assign op_bx    = i_cmd.cls_mul ? r_first_x : i_word.x;
    assign diff     = {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
    assign diff_ext = {{(ACC_W-PROD_W-1){diff[PROD_W]}}, diff};
    assign acc_fin  = r_acc + diff_ext;
    assign mag_full = acc_fin[ACC_W-1] ? ACC_W'(-acc_fin) : ACC_W'(acc_fin);

    always_comb begin
        case (i_mode)
            MODE_EVEN:  picked = !r_n[0];
            MODE_ODD:   picked = r_n[0];
            MODE_EXACT: picked = (r_n == i_target);
            default:    picked = 1'b1;
        endcase
    end

    assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_mag);

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign den    = {1'b0, r_pick, 1'b0};
    assign rem_ge = (rem_sh >= den);

    assign bad_target = (i_mode == MODE_EXACT) && (i_target <= TARGET_W'(BAD_TARGET_MAX));
    assign empty      = (r_poly_cnt == '0);
    assign mean_sat   = (r_num[NUM_W-1:SUM_W] != '0) ? '1 : r_num[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_load || i_cmd.cls_mul) begin
            r_pa <= PROD_W'(r_prev_x * op_by);
            r_pb <= PROD_W'(op_bx * r_prev_y);
        end
        if (i_cmd.cls_acc) begin
            r_mag <= (mag_full[ACC_W-1:AREA_W] != '0) ? '1 : mag_full[AREA_W-1:0];
            r_n   <= r_vcount;
        end
        if (i_cmd.div_prep) begin
            r_num <= {r_sum, 3'b000} + {4'b0000, r_sum} + {r_sum, 1'b0}
                     - {4'b0000, r_sum} + NUM_W'(r_pick);
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], rem_ge};
        end
        if (i_cmd.out_load) begin
            r_out.twice_area_sum   <= bad_target ? '0 : r_sum;
            r_out.selected_count   <= bad_target ? '0 : r_pick;
            r_out.mean_area_tenths <= (bad_target || r_pick == '0) ? '0 : mean_sat;
            r_out.max_twice_area   <= empty ? '0 : r_max_area;
            r_out.min_twice_area   <= empty ? '0 : r_min_area;
            r_out.max_vertices     <= empty ? '0 : r_max_n;
            r_out.min_vertices     <= empty ? '0 : r_min_n;
            r_out.status           <= bad_target ? STATUS_BAD_TARGET :
                                      (empty ? STATUS_EMPTY : STATUS_VALID);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_acc      <= '0;
            r_vcount   <= '0;
            r_add      <= 1'b0;
            r_last     <= 1'b0;
            r_sum      <= '0;
            r_poly_cnt <= '0;
            r_pick     <= '0;
            r_max_area <= '0;
            r_min_area <= '1;
            r_max_n    <= '0;
            r_min_n    <= '1;
            r_rem      <= '0;
            r_div_cnt  <= '0;
        end else begin
            if (i_cmd.vtx_load) begin
                r_last <= i_word.last_vertex;
                r_add  <= (r_vcount != '0) && (r_vcount < VCNT_W'(MAX_VERTICES));
                if (r_vcount < VCNT_W'(MAX_VERTICES)) begin
                    if (r_vcount == '0) begin
                        r_first_x <= i_word.x;
                        r_first_y <= i_word.y;
                        r_acc     <= '0;
                    end
                    r_prev_x <= i_word.x;
                    r_prev_y <= i_word.y;
                    r_vcount <= r_vcount + 1'b1;
                end
            end
            if (i_cmd.vtx_acc && r_add) begin
                r_acc <= acc_fin;
            end
            if (i_cmd.cls_acc) begin
                r_acc    <= '0;
                r_vcount <= '0;
            end
            if (i_cmd.cls_upd && (r_poly_cnt < CNT_W'(MAX_POLYGONS))) begin
                r_poly_cnt <= r_poly_cnt + 1'b1;
                if (r_mag > r_max_area) r_max_area <= r_mag;
                if (r_mag < r_min_area) r_min_area <= r_mag;
                if (r_n > r_max_n) r_max_n <= r_n;
                if (r_n < r_min_n) r_min_n <= r_n;
                if (picked) begin
                    r_pick <= r_pick + 1'b1;
                    r_sum  <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                end
            end
            if (i_cmd.div_prep) begin
                r_rem     <= '0;
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_rem     <= rem_ge ? REM_W'(rem_sh - den) : rem_sh[REM_W-1:0];
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_word  = r_out;
    assign o_valid = r_out_valid;

    assign o_sts.last     = r_last;
    assign o_sts.cnt_zero = (r_pick == '0);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_busy = r_out_valid && i_stall;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_valid)
        else $error("result word not presented after load");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_pick != '0))
        else $error("divider stepping with a zero divisor");

    a_vcount_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= VCNT_W'(MAX_VERTICES))
        else $error("vertex counter past its limit");

endmodule
`default_nettype wire

// ===== sv/pas_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon area statistics controller
// Sequences vertex accumulation, polygon closing and the end-of-set division.
// ----------------------------------------------------------------------------
module pas_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_action,
    output logic               o_stall,
    output pas_pkg::t_cmd      o_cmd,
    input  wire pas_pkg::t_sts i_sts
);
    import pas_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_action) begin
                        n_state = ST_DIV_PREP;
                    end else begin
                        o_cmd.vtx_load = 1'b1;
                        n_state        = ST_VTX_ACC;
                    end
                end
            end
            ST_VTX_ACC: begin
                o_cmd.vtx_acc = 1'b1;
                n_state       = i_sts.last ? ST_CLS_MUL : ST_IDLE;
            end
            ST_CLS_MUL: begin
                o_cmd.cls_mul = 1'b1;
                n_state       = ST_CLS_ACC;
            end
            ST_CLS_ACC: begin
                o_cmd.cls_acc = 1'b1;
                n_state       = ST_CLS_UPD;
            end
            ST_CLS_UPD: begin
                o_cmd.cls_upd = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_DIV_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_state        = i_sts.cnt_zero ? ST_OUT : ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state != ST_IDLE))
        else $error("accepted word did not start a sequence");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over an unread word");

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_RUN && i_sts.div_last) |=> (r_state == ST_OUT))
        else $error("division did not end in the output state");

endmodule
`default_nettype wire

// ===== sv/polygon_area_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon area statistics
// Shoelace twice-area per polygon with end-of-set statistics.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A vertex word occupies it while the
// multiplier pair forms the two cross products and then while their difference
// is added into the shoelace accumulator; a vertex word marked last_vertex then
// goes through the closing cross product against the first vertex, the absolute
// value and the statistics update. An end-of-set word goes straight to its
// result when no polygon was selected; otherwise the mean in tenths is formed
// as floor((10*sum + count) / (2*count)) by a restoring divider that retires
// one quotient bit per cycle over a 64-bit numerator. The result word then sits
// in an output register while the block goes on taking vertex words; only a
// second end-of-set word waits, at the end of its division, until the first
// result has been taken. Configuration is written through the APB-style port
// (select_mode at byte address 0, target_vertices at byte address 4); the user
// must write it only while the block is idle, which the block itself does not
// enforce. The selection mode is applied to each polygon as it closes, and the
// target check for a bad exact count is made when the set ends.
// ----------------------------------------------------------------------------
module polygon_area_statistics (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Vertex and end-of-set words.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire pas_pkg::t_in_word             i_word,
    // Result words.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output pas_pkg::t_out_word                 o_word,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pas_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pas_pkg::PDATA_W-1:0]   pwdata,
    output logic      [pas_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import pas_pkg::*;

    logic [MODE_W-1:0]   mode;
    logic [TARGET_W-1:0] target;
    t_cmd                cmd;
    t_sts                sts;

    // Register file; the mode and target are read by the datapath only when
    // a polygon closes and when a set ends.
    pas_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (mode),
        .o_target (target)
    );

    // The controller accepts a word only in its idle state and then walks
    // the datapath through the steps that the word calls for.
    pas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_word.action),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    // The datapath holds all set state, the divider and the result register.
    pas_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_word   (i_word),
        .i_mode   (mode),
        .i_target (target),
        .o_word   (o_word),
        .o_valid  (o_valid),
        .i_stall  (i_stall)
    );

endmodule
`default_nettype wire

// ===== test/tb_polygon_area_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area statistics testbench
// Streams vertex and end-of-set words into the block and checks every
// statistics word against a cycle-free model of the shoelace statistics. A
// directed opening covers the corner cases. Random sets then run under
// several selection settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_polygon_area_statistics;
    import pas_pkg::*;

    localparam int CLK_HALF = 2;
    // Vertex words can still be in the pipe when the last statistics
    // word appears.
    localparam int SETTLE_CYCLES = 100;
    // About 1200 words; even if every one were an end-of-set word with its
    // full division and the stall waits, a run stays far below this.
    localparam int CYCLE_LIMIT = 500_000;
    localparam int RANDOM_WORDS = 1100;
    localparam int SEGMENTS = 8;
    localparam int MAX_REPORTS = 10;
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam logic [63:0] AREA_CAP = (64'd1 << AREA_W) - 1;
    localparam logic [63:0] SUM_CAP = (64'd1 << SUM_W) - 1;

    typedef struct {
        t_in_word word;
        bit       hold;     // wait for all statistics words before sending
    } t_feed_entry;

    logic clk;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    polygon_area_statistics dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_word  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_word  (out_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus queue, expected statistics words and bookkeeping.
    t_feed_entry vertex_feed[$];
    t_out_word   expected_reports[$];
    int          words_queued = 0;
    int          words_accepted = 0;
    int          reports_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        word_taken = 1'b0;

    // Model copy of the configuration registers.
    logic [MODE_W-1:0]   model_mode;
    logic [TARGET_W-1:0] model_target;

    // Model copy of the polygon being built and of the set statistics.
    longint              anchor_x, anchor_y;
    longint              last_x, last_y;
    logic [63:0]         open_cross_sum;
    int                  open_vertices;
    logic [63:0]         picked_area_total;
    int                  set_polygons;
    int                  picked_polygons;
    logic [63:0]         largest_area;
    logic [63:0]         smallest_area;
    logic [VCNT_W-1:0]   most_vertices;
    logic [VCNT_W-1:0]   fewest_vertices;

    // ------------------------------------------------------------------
    // Area model.
    // ------------------------------------------------------------------
    function automatic logic [63:0] side_cross(longint ax, longint ay, longint bx, longint by);
        return ax * by - bx * ay;
    endfunction

    function automatic void clear_set_stats();
        anchor_x = 0;
        anchor_y = 0;
        last_x = 0;
        last_y = 0;
        open_cross_sum = '0;
        open_vertices = 0;
        picked_area_total = '0;
        set_polygons = 0;
        picked_polygons = 0;
        largest_area = '0;
        smallest_area = AREA_CAP;
        most_vertices = '0;
        fewest_vertices = '1;
    endfunction

    function automatic bit polygon_picked(int n);
        case (model_mode)
            MODE_EVEN:  return (n % 2) == 0;
            MODE_ODD:   return (n % 2) == 1;
            MODE_EXACT: return n == model_target;
            default:    return 1'b1;
        endcase
    endfunction

    function automatic void close_polygon();
        logic [63:0] total;
        logic [63:0] mag;
        int          n;
        total = open_cross_sum + side_cross(last_x, last_y, anchor_x, anchor_y);
        mag = total[63] ? (~total + 64'd1) : total;
        if (mag > AREA_CAP)
            mag = AREA_CAP;
        n = open_vertices;
        open_vertices = 0;
        open_cross_sum = '0;
        // Polygons beyond the set capacity leave no trace.
        if (set_polygons >= MAX_POLYGONS)
            return;
        set_polygons++;
        if (mag > largest_area)
            largest_area = mag;
        if (mag < smallest_area)
            smallest_area = mag;
        if (n > most_vertices)
            most_vertices = VCNT_W'(n);
        if (n < fewest_vertices)
            fewest_vertices = VCNT_W'(n);
        if (polygon_picked(n)) begin
            picked_polygons++;
            picked_area_total = (SUM_CAP - picked_area_total < mag) ? SUM_CAP
                                                                     : picked_area_total + mag;
        end
    endfunction

    function automatic t_out_word set_report();
        t_out_word   r;
        logic [63:0] cnt, quot, rem, mean;
        bit          empty;
        cnt = 64'(picked_polygons);
        mean = '0;
        empty = (set_polygons == 0);
        if (cnt != 0) begin
            quot = picked_area_total / cnt;
            rem = picked_area_total % cnt;
            mean = 5 * quot + (10 * rem + cnt) / (2 * cnt);
            if (mean > SUM_CAP)
                mean = SUM_CAP;
        end
        r.twice_area_sum = picked_area_total[SUM_W-1:0];
        r.selected_count = cnt[CNT_W-1:0];
        r.mean_area_tenths = mean[SUM_W-1:0];
        r.status = STATUS_VALID;
        // A bad exact-count target hides the selected statistics and wins
        // over the empty-set status.
        if (model_mode == MODE_EXACT && model_target <= BAD_TARGET_MAX) begin
            r.status = STATUS_BAD_TARGET;
            r.twice_area_sum = '0;
            r.selected_count = '0;
            r.mean_area_tenths = '0;
        end else if (empty) begin
            r.status = STATUS_EMPTY;
        end
        r.max_twice_area = empty ? '0 : largest_area[AREA_W-1:0];
        r.min_twice_area = empty ? '0 : smallest_area[AREA_W-1:0];
        r.max_vertices = empty ? '0 : most_vertices;
        r.min_vertices = empty ? '0 : fewest_vertices;
        return r;
    endfunction

    function automatic void advance_area_model(t_in_word w);
        longint px, py;
        if (w.action == 1'b0) begin
            px = longint'(w.x);
            py = longint'(w.y);
            // Vertices past the per-polygon cap are dropped, but their
            // last_vertex mark still closes the polygon.
            if (open_vertices < MAX_VERTICES) begin
                if (open_vertices == 0) begin
                    anchor_x = px;
                    anchor_y = py;
                    open_cross_sum = '0;
                end else begin
                    open_cross_sum += side_cross(last_x, last_y, px, py);
                end
                last_x = px;
                last_y = py;
                open_vertices++;
            end
            if (w.last_vertex && open_vertices != 0)
                close_polygon();
        end else begin
            expected_reports.push_back(set_report());
            clear_set_stats();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR: %s at statistics word %0d: expected 0x%0h, got 0x%0h",
                     what, reports_seen, want, got);
    endfunction

    function automatic void check_report(t_out_word got);
        t_out_word want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: statistics word %0d arrived with none expected: 0x%0h",
                         reports_seen, got);
            return;
        end
        want = expected_reports.pop_front();
        if (got.twice_area_sum !== want.twice_area_sum)
            note_mismatch("twice_area_sum", want.twice_area_sum, got.twice_area_sum);
        if (got.selected_count !== want.selected_count)
            note_mismatch("selected_count", want.selected_count, got.selected_count);
        if (got.mean_area_tenths !== want.mean_area_tenths)
            note_mismatch("mean_area_tenths", want.mean_area_tenths, got.mean_area_tenths);
        if (got.max_twice_area !== want.max_twice_area)
            note_mismatch("max_twice_area", want.max_twice_area, got.max_twice_area);
        if (got.min_twice_area !== want.min_twice_area)
            note_mismatch("min_twice_area", want.min_twice_area, got.min_twice_area);
        if (got.max_vertices !== want.max_vertices)
            note_mismatch("max_vertices", want.max_vertices, got.max_vertices);
        if (got.min_vertices !== want.min_vertices)
            note_mismatch("min_vertices", want.min_vertices, got.min_vertices);
        if (got.status !== want.status)
            note_mismatch("status", want.status, got.status);
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit, driver and monitor.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Inputs change on the falling edge. A word that was not taken stays put;
    // otherwise the next one goes out unless the sender idles this cycle.
    always @(negedge clk) begin
        logic     next_valid;
        t_in_word next_word;
        next_valid = in_valid;
        next_word = in_word;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else if (!in_valid || word_taken) begin
            next_valid = 1'b0;
            if (vertex_feed.size() != 0 &&
                !(vertex_feed[0].hold && expected_reports.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
                next_word = vertex_feed[0].word;
                next_valid = 1'b1;
                void'(vertex_feed.pop_front());
            end
        end
        in_valid <= next_valid;
        in_word <= next_word;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both handshakes are sampled on the rising edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            word_taken <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                word_taken <= 1'b1;
                words_accepted++;
                advance_area_model(in_word);
            end else begin
                word_taken <= 1'b0;
            end
            if (out_valid && !out_stall) begin
                check_report(out_word);
                reports_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_in_word vertex_word(int x, int y, bit last);
        t_in_word w;
        w.action = 1'b0;
        w.x = COORD_BITS'(x);
        w.y = COORD_BITS'(y);
        w.last_vertex = last;
        return w;
    endfunction

    function automatic t_in_word end_word(int x, int y, bit last);
        t_in_word w;
        w.action = 1'b1;
        w.x = COORD_BITS'(x);
        w.y = COORD_BITS'(y);
        w.last_vertex = last;
        return w;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return int'($urandom_range(64)) - 32;
            default: return int'($urandom_range(65535)) + COORD_MIN;
        endcase
    endfunction

    task automatic push_word(t_in_word w, bit hold);
        t_feed_entry e;
        e.word = w;
        e.hold = hold;
        vertex_feed.push_back(e);
        words_queued++;
    endtask

    task automatic push_vertex(int x, int y, bit last);
        push_word(vertex_word(x, y, last), 1'b0);
    endtask

    // Waits until every queued word is taken and every statistics word has
    // come back, then lets the block drain any trailing vertex work.
    task automatic settle(int extra);
        @(negedge clk);
        while (words_accepted != words_queued || expected_reports.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        // Read the register straight back.
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== value)
            note_mismatch("register readback", value, got);
    endtask

    task automatic set_selection(logic [MODE_W-1:0] mode, logic [TARGET_W-1:0] target);
        settle(SETTLE_CYCLES);
        write_reg(REG_SELECT_MODE, PDATA_W'(mode));
        write_reg(REG_TARGET, PDATA_W'(target));
        model_mode = mode;
        model_target = target;
    endtask

    // One random set: mostly closed polygons, now and then an empty set or
    // an open polygon left dangling at the end-of-set word.
    task automatic queue_random_set(bit hold_first, inout int count);
        int n_poly;
        int n_vert;
        bit hold;
        hold = hold_first;
        n_poly = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        for (int p = 0; p < n_poly; p++) begin
            case ($urandom_range(19))
                0:          n_vert = $urandom_range(1, 2);
                1, 2, 3:    n_vert = $urandom_range(9, 24);
                default:    n_vert = $urandom_range(3, 8);
            endcase
            for (int v = 0; v < n_vert; v++) begin
                push_word(vertex_word(pick_coord(), pick_coord(), v == n_vert - 1), hold);
                hold = 1'b0;
                count++;
            end
        end
        if ($urandom_range(9) == 0) begin
            n_vert = $urandom_range(1, 4);
            for (int v = 0; v < n_vert; v++) begin
                push_word(vertex_word(pick_coord(), pick_coord(), 1'b0), hold);
                hold = 1'b0;
                count++;
            end
        end
        push_word(end_word(pick_coord(), pick_coord(), 1'($urandom_range(1))), hold);
        count++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int                  seg_words;
        int                  set_no;
        int                  leftover;
        logic [MODE_W-1:0]   mode;
        logic [TARGET_W-1:0] target;

        model_mode = MODE_RESET;
        model_target = TARGET_RESET;
        clear_set_stats();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, select all. Full-range triangles in both
        // orientations, one- and two-vertex polygons, an open polygon left
        // at the end of the set, and junk fields on the end-of-set word.
        push_vertex(COORD_MIN, COORD_MIN, 1'b0);
        push_vertex(COORD_MAX, COORD_MIN, 1'b0);
        push_vertex(COORD_MAX, COORD_MAX, 1'b1);
        push_vertex(COORD_MIN, COORD_MAX, 1'b0);
        push_vertex(COORD_MAX, COORD_MAX, 1'b0);
        push_vertex(COORD_MAX, COORD_MIN, 1'b1);
        push_vertex(-1, -1, 1'b1);
        push_vertex(0, 0, 1'b0);
        push_vertex(12345, -4321, 1'b1);
        push_vertex(5, 5, 1'b0);
        push_vertex(6, 7, 1'b0);
        push_word(end_word(-1, -1, 1'b1), 1'b0);
        // A set with no polygon at all.
        push_word(end_word(0, 0, 1'b0), 1'b0);

        // Exact-count mode with a target of two or less.
        set_selection(MODE_EXACT, 11'd2);
        push_vertex(0, 0, 1'b0);
        push_vertex(9, 0, 1'b0);
        push_vertex(9, 9, 1'b0);
        push_vertex(0, 9, 1'b1);
        push_word(end_word(COORD_MAX, COORD_MIN, 1'b0), 1'b0);
        // The bad target wins over an empty set.
        set_selection(MODE_EXACT, 11'd0);
        push_word(end_word(0, 0, 1'b0), 1'b0);

        // Even counts only, with a target of 1024, the vertex cap, written.
        set_selection(MODE_EVEN, 11'd1024);
        push_vertex(0, 0, 1'b0);
        push_vertex(10, 0, 1'b0);
        push_vertex(10, 10, 1'b0);
        push_vertex(0, 10, 1'b1);
        push_vertex(0, 0, 1'b0);
        push_vertex(7, 0, 1'b0);
        push_vertex(0, 3, 1'b1);
        push_word(end_word(0, 0, 1'b0), 1'b0);

        // Random sets. Two settings per idling pattern: none, sender idle,
        // receiver stalling, both.
        set_no = 0;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mode = MODE_W'(seg % 4);
            if (mode == MODE_EXACT)
                target = (seg < 4) ? TARGET_W'($urandom_range(3, 6))
                                   : TARGET_W'($urandom_range(1, 8));
            else
                target = TARGET_W'($urandom_range(1024));
            set_selection(mode, target);
            case (seg / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            seg_words = 0;
            while (seg_words < RANDOM_WORDS / SEGMENTS) begin
                queue_random_set(set_no == 2 || $urandom_range(5) == 0, seg_words);
                set_no++;
            end
        end

        settle(SETTLE_CYCLES);
        leftover = expected_reports.size();
        if (mismatches == 0 && leftover == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pas_pkg.sv
sv/pas_regs.sv
sv/pas_dp.sv
sv/pas_ctrl.sv
sv/polygon_area_statistics.sv
test/tb_polygon_area_statistics.sv
